/* rtl/fsbd_pkg.sv */
// Package: types and constants for the flux stream byte decoder.
`timescale 1ns / 1ps

package fsbd_pkg;

  typedef enum logic [2:0] {
    PH_CMD    = 3'd0,
    PH_F2_LO  = 3'd1,
    PH_F3_HI  = 3'd2,
    PH_F3_LO  = 3'd3,
    PH_SKIP   = 3'd4,
    PH_OOB_TY = 3'd5,
    PH_OOB_SL = 3'd6,
    PH_OOB_SH = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_END   = 2'd0,
    KIND_FLUX  = 2'd1,
    KIND_INDEX = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REASON_NONE  = 2'd0,
    REASON_END   = 2'd1,
    REASON_TRUNC = 2'd2,
    REASON_LIMIT = 2'd3
  } reason_t;

  typedef enum logic [1:0] {
    CFG_MAX_FLUX  = 2'd0,
    CFG_MAX_INDEX = 2'd1,
    CFG_NS_SCALE  = 2'd2
  } cfg_idx_t;

  // command bytes
  localparam logic [7:0] CMD_FLUX2_MAX = 8'h07;
  localparam logic [7:0] CMD_NOP1      = 8'h08;
  localparam logic [7:0] CMD_NOP2      = 8'h09;
  localparam logic [7:0] CMD_NOP3      = 8'h0A;
  localparam logic [7:0] CMD_OVL16     = 8'h0B;
  localparam logic [7:0] CMD_FLUX3     = 8'h0C;
  localparam logic [7:0] CMD_OOB       = 8'h0D;

  // out-of-band block types
  localparam logic [7:0] OOB_INDEX  = 8'h02;
  localparam logic [7:0] OOB_STREND = 8'h03;
  localparam logic [7:0] OOB_EOF    = 8'h0D;

  localparam logic [15:0] INDEX_MIN_SIZE = 16'd8;
  localparam logic [31:0] OVL_TICKS      = 32'h0001_0000;
  localparam logic [63:0] ROUND_HALF     = 64'h0000_0000_0080_0000;

  localparam logic [23:0] MAX_FLUX_RST = 24'hFF_FFFF;
  localparam logic [4:0]  MAX_IDX_RST  = 5'd16;
  localparam logic [31:0] NS_SCALE_RST = 32'd698252662;

endpackage

/* rtl/flux_stream_byte_decoder.sv */
// Top level: flux stream byte decoder, parse, tick scaling and result register.
`timescale 1ns / 1ps

// channel  | handshake            | payload
// ---------+----------------------+------------------------------------------
// in       | in_valid / in_ready  | in_stream_byte, in_last_byte
// out      | out_valid/out_ready  | out_kind, out_flux_ns, out_index_flux_pos,
//          |                      | out_stream_done, out_stop_reason,
//          |                      | out_total_flux, out_total_index
// cfg      | cfg_valid/cfg_ready  | cfg_index, cfg_data (cfg_ready always high)
//
// One word per cycle. Four register stages: input, parse, 32x32 multiply,
// round/saturate into the output register. The parse stage updates stream
// state as each accepted byte passes it, so that stage sets the rate.
// The whole pipeline holds while the output register is full and out_ready
// is low; in_ready follows that. Reset (rst_n low, synchronous) clears the
// stream state and loads the register defaults.

module flux_stream_byte_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_stream_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [31:0] out_flux_ns,
  output logic [23:0] out_index_flux_pos,
  output logic        out_stream_done,
  output logic [1:0]  out_stop_reason,
  output logic [23:0] out_total_flux,
  output logic [4:0]  out_total_index,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic advance;

  // config registers
  logic [23:0] max_flux_r;
  logic [4:0]  max_idx_r;
  logic [31:0] ns_scale_r;

  // input stage
  logic        v1_r;
  logic [7:0]  byte_r;
  logic        last_r;

  // stream state
  fsbd_pkg::phase_t  phase_r, phase_nxt;
  logic [16:0]       skip_r, skip_nxt;
  logic [7:0]        type_r, type_nxt;
  logic [15:0]       held_r, held_nxt;
  logic [31:0]       ovf_r, ovf_nxt;
  logic [23:0]       fcnt_r, fcnt_nxt;
  logic [4:0]        icnt_r, icnt_nxt;
  logic              stop_r, stop_nxt;
  fsbd_pkg::reason_t code_r, code_nxt;

  // parse results
  logic              emit;
  fsbd_pkg::kind_t   kind;
  logic [31:0]       ticks;
  logic [23:0]       ipos;
  fsbd_pkg::reason_t reason;
  logic              take;
  logic [15:0]       raw;
  logic [15:0]       size;
  logic [23:0]       fcnt_inc;

  // parse stage
  logic        v2_r;
  logic [31:0] ticks_r;
  logic [1:0]  kind2_r;
  logic [23:0] ipos2_r;
  logic        done2_r;
  logic [1:0]  reason2_r;
  logic [23:0] tflux2_r;
  logic [4:0]  tidx2_r;

  // multiply stage
  logic        v3_r;
  logic [63:0] prod_r;
  logic [1:0]  kind3_r;
  logic [23:0] ipos3_r;
  logic        done3_r;
  logic [1:0]  reason3_r;
  logic [23:0] tflux3_r;
  logic [4:0]  tidx3_r;

  // round stage
  logic [63:0] rounded;
  logic [31:0] ns_sat;

  // output register
  logic        out_valid_r;
  logic [31:0] ns_r;
  logic [1:0]  kind_o_r;
  logic [23:0] ipos_o_r;
  logic        done_o_r;
  logic [1:0]  reason_o_r;
  logic [23:0] tflux_o_r;
  logic [4:0]  tidx_o_r;

  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = advance;
  assign cfg_ready = 1'b1;

  always_comb begin
    phase_nxt = phase_r;
    skip_nxt  = skip_r;
    type_nxt  = type_r;
    held_nxt  = held_r;
    ovf_nxt   = ovf_r;
    fcnt_nxt  = fcnt_r;
    icnt_nxt  = icnt_r;
    stop_nxt  = stop_r || (fcnt_r >= max_flux_r);
    code_nxt  = stop_r ? code_r : fsbd_pkg::REASON_LIMIT;
    emit      = 1'b0;
    kind      = fsbd_pkg::KIND_END;
    ticks     = 32'd0;
    ipos      = 24'd0;
    reason    = fsbd_pkg::REASON_NONE;
    take      = 1'b0;
    raw       = 16'd0;
    size      = {byte_r, held_r[7:0]};
    fcnt_inc  = fcnt_r + 24'd1;

    if (!stop_nxt) begin
      unique case (phase_r)
        fsbd_pkg::PH_CMD: begin
          priority if (byte_r == fsbd_pkg::CMD_OOB) begin
            phase_nxt = fsbd_pkg::PH_OOB_TY;
          end else if (byte_r <= fsbd_pkg::CMD_FLUX2_MAX) begin
            held_nxt  = {13'd0, byte_r[2:0]};
            phase_nxt = fsbd_pkg::PH_F2_LO;
          end else if (byte_r == fsbd_pkg::CMD_NOP1) begin
            phase_nxt = fsbd_pkg::PH_CMD;
          end else if (byte_r == fsbd_pkg::CMD_NOP2) begin
            skip_nxt  = 17'd1;
            phase_nxt = fsbd_pkg::PH_SKIP;
          end else if (byte_r == fsbd_pkg::CMD_NOP3) begin
            skip_nxt  = 17'd2;
            phase_nxt = fsbd_pkg::PH_SKIP;
          end else if (byte_r == fsbd_pkg::CMD_OVL16) begin
            ovf_nxt = ovf_r + fsbd_pkg::OVL_TICKS;
          end else if (byte_r == fsbd_pkg::CMD_FLUX3) begin
            phase_nxt = fsbd_pkg::PH_F3_HI;
          end else begin
            take = 1'b1;
            raw  = {8'd0, byte_r};
          end
        end
        fsbd_pkg::PH_F2_LO, fsbd_pkg::PH_F3_LO: begin
          take      = 1'b1;
          raw       = {held_r[7:0], byte_r};
          held_nxt  = 16'd0;
          phase_nxt = fsbd_pkg::PH_CMD;
        end
        fsbd_pkg::PH_F3_HI: begin
          held_nxt  = {8'd0, byte_r};
          phase_nxt = fsbd_pkg::PH_F3_LO;
        end
        fsbd_pkg::PH_SKIP: begin
          skip_nxt = skip_r - 17'd1;
          if (skip_r == 17'd1) begin
            phase_nxt = fsbd_pkg::PH_CMD;
          end
        end
        fsbd_pkg::PH_OOB_TY: begin
          type_nxt  = byte_r;
          phase_nxt = fsbd_pkg::PH_OOB_SL;
        end
        fsbd_pkg::PH_OOB_SL: begin
          held_nxt  = {8'd0, byte_r};
          phase_nxt = fsbd_pkg::PH_OOB_SH;
        end
        fsbd_pkg::PH_OOB_SH: begin
          held_nxt  = 16'd0;
          skip_nxt  = {1'b0, size};
          phase_nxt = (size == 16'd0) ? fsbd_pkg::PH_CMD : fsbd_pkg::PH_SKIP;
          priority if (type_r == fsbd_pkg::OOB_INDEX && size >= fsbd_pkg::INDEX_MIN_SIZE
                       && icnt_r < max_idx_r) begin
            emit     = 1'b1;
            kind     = fsbd_pkg::KIND_INDEX;
            ipos     = fcnt_r;
            icnt_nxt = icnt_r + 5'd1;
          end else if (type_r == fsbd_pkg::OOB_STREND || type_r == fsbd_pkg::OOB_EOF) begin
            skip_nxt  = skip_r;
            stop_nxt  = 1'b1;
            code_nxt  = fsbd_pkg::REASON_END;
            phase_nxt = fsbd_pkg::PH_CMD;
          end else begin
            emit = 1'b0;
          end
        end
      endcase
    end

    if (take) begin
      emit     = 1'b1;
      kind     = fsbd_pkg::KIND_FLUX;
      ticks    = {16'd0, raw} + ovf_r;
      ovf_nxt  = 32'd0;
      fcnt_nxt = fcnt_inc;
      if (fcnt_inc >= max_flux_r) begin
        stop_nxt = 1'b1;
        code_nxt = fsbd_pkg::REASON_LIMIT;
      end
    end

    if (last_r) begin
      if (stop_nxt) begin
        reason = code_nxt;
      end else if (phase_nxt != fsbd_pkg::PH_CMD && phase_nxt != fsbd_pkg::PH_SKIP) begin
        reason = fsbd_pkg::REASON_TRUNC;
      end
    end
  end

  assign rounded = prod_r + fsbd_pkg::ROUND_HALF;
  assign ns_sat  = (|rounded[63:56]) ? 32'hFFFF_FFFF : rounded[55:24];

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_flux_r  <= fsbd_pkg::MAX_FLUX_RST;
      max_idx_r   <= fsbd_pkg::MAX_IDX_RST;
      ns_scale_r  <= fsbd_pkg::NS_SCALE_RST;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= fsbd_pkg::PH_CMD;
      skip_r      <= 17'd0;
      type_r      <= 8'd0;
      held_r      <= 16'd0;
      ovf_r       <= 32'd0;
      fcnt_r      <= 24'd0;
      icnt_r      <= 5'd0;
      stop_r      <= 1'b0;
      code_r      <= fsbd_pkg::REASON_NONE;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          fsbd_pkg::CFG_MAX_FLUX:  max_flux_r <= cfg_data[23:0];
          fsbd_pkg::CFG_MAX_INDEX: max_idx_r  <= cfg_data[4:0];
          fsbd_pkg::CFG_NS_SCALE:  ns_scale_r <= cfg_data;
          default: ;
        endcase
      end
      if (advance) begin
        v1_r        <= in_valid;
        v2_r        <= v1_r && (emit || last_r);
        v3_r        <= v2_r;
        out_valid_r <= v3_r;
        if (v1_r) begin
          if (last_r) begin
            phase_r <= fsbd_pkg::PH_CMD;
            skip_r  <= 17'd0;
            type_r  <= 8'd0;
            held_r  <= 16'd0;
            ovf_r   <= 32'd0;
            fcnt_r  <= 24'd0;
            icnt_r  <= 5'd0;
            stop_r  <= 1'b0;
            code_r  <= fsbd_pkg::REASON_NONE;
          end else begin
            phase_r <= phase_nxt;
            skip_r  <= skip_nxt;
            type_r  <= type_nxt;
            held_r  <= held_nxt;
            ovf_r   <= ovf_nxt;
            fcnt_r  <= fcnt_nxt;
            icnt_r  <= icnt_nxt;
            stop_r  <= stop_nxt;
            code_r  <= code_nxt;
          end
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (advance) begin
      byte_r    <= in_stream_byte;
      last_r    <= in_last_byte;
      ticks_r   <= ticks;
      kind2_r   <= kind;
      ipos2_r   <= ipos;
      done2_r   <= last_r;
      reason2_r <= reason;
      tflux2_r  <= fcnt_nxt;
      tidx2_r   <= icnt_nxt;
      prod_r    <= ticks_r * ns_scale_r;
      kind3_r   <= kind2_r;
      ipos3_r   <= ipos2_r;
      done3_r   <= done2_r;
      reason3_r <= reason2_r;
      tflux3_r  <= tflux2_r;
      tidx3_r   <= tidx2_r;
      ns_r       <= ns_sat;
      kind_o_r   <= kind3_r;
      ipos_o_r   <= ipos3_r;
      done_o_r   <= done3_r;
      reason_o_r <= reason3_r;
      tflux_o_r  <= tflux3_r;
      tidx_o_r   <= tidx3_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = kind_o_r;
  assign out_flux_ns        = ns_r;
  assign out_index_flux_pos = ipos_o_r;
  assign out_stream_done    = done_o_r;
  assign out_stop_reason    = reason_o_r;
  assign out_total_flux     = tflux_o_r;
  assign out_total_index    = tidx_o_r;

endmodule
